// ===== rtl/core/u8m7_pkg.sv =====
// Package for the UTF-8 to modified UTF-7 encoder.
// Holds the job descriptor passed from the front end to the back end,
// the character constants and the base64 alphabet. No dependencies.
package u8m7_pkg;

  // Characters that the encoder tests for or writes.
  localparam logic [7:0] BYTE_NUL        = 8'h00;
  localparam logic [7:0] BYTE_SPACE      = 8'h20;
  localparam logic [7:0] BYTE_AMP        = 8'h26;
  localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
  localparam logic [7:0] BYTE_TILDE      = 8'h7E;
  localparam logic [7:0] BYTE_ASCII_END  = 8'h80;

  localparam logic [6:0] CHAR_NUL        = 7'h00;
  localparam logic [6:0] CHAR_AMP        = 7'h26;
  localparam logic [6:0] CHAR_DASH       = 7'h2D;
  localparam logic [6:0] CHAR_UNDERSCORE = 7'h5F;

  // Surrogate construction.
  localparam logic [20:0] PLANE1_BASE    = 21'h10000;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [5:0]  LOW_SURR_TOP   = 6'b110111;

  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned BITS_W  = 36;

  // One job: the ordered characters that a single input byte produces.
  // Order of output: amp, digits, dash, chr, cdash.
  typedef struct packed {
    logic              amp;       // opening '&' of a base64 run
    logic [2:0]        ndig;      // number of base64 digits still owed
    logic [BITS_W-1:0] bits;      // digit bits, first digit in the top six
    logic              dash;      // '-' closing a base64 run
    logic              has_char;  // a literal character follows
    logic [6:0]        chr;       // that character
    logic              cdash;     // '-' after a literal '&'
    logic              is_end;    // chr is the string terminator
  } u8m7_job_t;

  // Base64 alphabet "A-Za-z0-9+,".
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2C;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/u8m7_ifs.sv =====
// Channel interfaces for the UTF-8 to modified UTF-7 encoder.
// One carries input bytes, the other output characters. No dependencies.
interface u8m7_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface u8m7_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_string;
  logic       last_of_item;

  modport source (output valid, output out_char, output end_of_string,
                  output last_of_item, input ready);
  modport sink (input valid, input out_char, input end_of_string,
                input last_of_item, output ready);
endinterface

// ===== rtl/core/u8m7_front.sv =====
// Front end: accepts UTF-8 bytes, keeps the encoder state and turns each
// byte into a job descriptor. Depends on u8m7_pkg and u8m7_byte_if.
module u8m7_front import u8m7_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  u8m7_byte_if.sink       byte_ch,
  input  logic            q_full,
  output logic            push,
  output u8m7_job_t       job
);

  logic        space_map;
  logic        base64_mode, base64_mode_next;
  logic [3:0]  bit_buffer, bit_buffer_next;
  logic [2:0]  bits_pending, bits_pending_next;
  logic [2:0]  seq_total, seq_total_next;
  logic [2:0]  seq_pos, seq_pos_next;
  logic [20:0] code_point, code_point_next;

  logic        accept;
  logic [7:0]  c;
  logic        is_zero;
  logic        printable;
  logic        cp_ready;
  logic [2:0]  pos_inc;
  logic        big;
  logic [20:0] v;
  logic [15:0] u1;
  logic [15:0] u2;

  assign byte_ch.ready = !q_full;
  assign accept        = byte_ch.valid && !q_full;
  assign c             = byte_ch.in_byte;

  always_comb begin
    is_zero   = (c == BYTE_NUL);
    printable = (c >= BYTE_SPACE) && (c <= BYTE_TILDE) &&
                ((c != BYTE_UNDERSCORE) || !space_map);
    pos_inc   = seq_pos + 3'd1;

    base64_mode_next  = base64_mode;
    bit_buffer_next   = bit_buffer;
    bits_pending_next = bits_pending;
    seq_total_next    = seq_total;
    seq_pos_next      = seq_pos;
    code_point_next   = code_point;
    cp_ready          = 1'b0;
    job               = '0;

    if (is_zero || printable) begin
      // Leaving base64: flush the leftover bits padded with zeros, then '-'.
      job.dash = base64_mode;
      if (base64_mode && (bits_pending != 3'd0)) begin
        job.ndig = 3'd1;
        job.bits[BITS_W-1 -: DIGIT_W] = bits_pending[2] ? {bit_buffer, 2'b00}
                                                        : {bit_buffer[1:0], 4'b0000};
      end
      job.has_char      = 1'b1;
      base64_mode_next  = 1'b0;
      bits_pending_next = 3'd0;
      seq_total_next    = 3'd0;
      seq_pos_next      = 3'd0;
      if (is_zero) begin
        job.chr         = CHAR_NUL;
        job.is_end      = 1'b1;
        bit_buffer_next = 4'd0;
        code_point_next = 21'd0;
      end else begin
        job.chr   = (space_map && (c == BYTE_SPACE)) ? CHAR_UNDERSCORE : c[6:0];
        job.cdash = (c == BYTE_AMP);
      end
    end else begin
      job.amp          = !base64_mode;
      base64_mode_next = 1'b1;
      if (c < BYTE_ASCII_END) begin
        code_point_next = {13'd0, c};
        cp_ready        = 1'b1;
      end else if (seq_total != 3'd0) begin
        code_point_next = {code_point[14:0], c[5:0]};
        seq_pos_next    = pos_inc;
        cp_ready        = (pos_inc >= seq_total);
      end else begin
        seq_pos_next = 3'd1;
        if (c < 8'hE0) begin
          seq_total_next  = 3'd2;
          code_point_next = {16'd0, c[4:0]};
        end else if (c < 8'hF0) begin
          seq_total_next  = 3'd3;
          code_point_next = {17'd0, c[3:0]};
        end else begin
          seq_total_next  = 3'd4;
          code_point_next = {18'd0, c[2:0]};
        end
      end
    end

    // UTF-16 units of the finished code point.
    big = |code_point_next[20:16];
    v   = code_point_next - PLANE1_BASE;
    u1  = big ? (16'(v[20:10]) + HIGH_SURR_BASE) : code_point_next[15:0];
    u2  = {LOW_SURR_TOP, v[9:0]};

    if (cp_ready) begin
      seq_total_next  = 3'd0;
      seq_pos_next    = 3'd0;
      bit_buffer_next = big ? u2[3:0] : u1[3:0];
      case ({big, bits_pending[2:1]})
        3'b000: begin
          job.bits = {u1, 20'd0};
          job.ndig = 3'd2;
          bits_pending_next = 3'd4;
        end
        3'b001: begin
          job.bits = {bit_buffer[1:0], u1, 18'd0};
          job.ndig = 3'd3;
          bits_pending_next = 3'd0;
        end
        3'b010: begin
          job.bits = {bit_buffer, u1, 16'd0};
          job.ndig = 3'd3;
          bits_pending_next = 3'd2;
        end
        3'b100: begin
          job.bits = {u1, u2, 4'd0};
          job.ndig = 3'd5;
          bits_pending_next = 3'd2;
        end
        3'b101: begin
          job.bits = {bit_buffer[1:0], u1, u2, 2'd0};
          job.ndig = 3'd5;
          bits_pending_next = 3'd4;
        end
        3'b110: begin
          job.bits = {bit_buffer, u1, u2};
          job.ndig = 3'd6;
          bits_pending_next = 3'd0;
        end
        default: begin
          job.bits = '0;
          job.ndig = 3'd0;
          bits_pending_next = 3'd0;
        end
      endcase
    end
  end

  // Steps that only collect part of a sequence inside base64 produce nothing.
  assign push = accept && (is_zero || printable || job.amp || cp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      space_map <= 1'b0;
    end else if (cfg_we) begin
      space_map <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base64_mode  <= 1'b0;
      bit_buffer   <= 4'd0;
      bits_pending <= 3'd0;
      seq_total    <= 3'd0;
      seq_pos      <= 3'd0;
      code_point   <= 21'd0;
    end else if (accept) begin
      base64_mode  <= base64_mode_next;
      bit_buffer   <= bit_buffer_next;
      bits_pending <= bits_pending_next;
      seq_total    <= seq_total_next;
      seq_pos      <= seq_pos_next;
      code_point   <= code_point_next;
    end
  end

endmodule

// ===== rtl/core/u8m7_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on u8m7_pkg.
module u8m7_queue import u8m7_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  u8m7_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      nonempty,
  output u8m7_job_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8m7_job_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/u8m7_back.sv =====
// Back end: takes jobs from the queue and, while the output is not stalled, writes one
// character per cycle into the output register. Depends on u8m7_pkg and u8m7_char_if.
module u8m7_back import u8m7_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  u8m7_job_t  q_head,
  output logic       pop,
  u8m7_char_if.source char_ch
);

  u8m7_job_t  cur;
  u8m7_job_t  cur_next;
  logic       cur_valid;
  logic       out_valid;
  logic [6:0] out_char;
  logic       out_end;
  logic       out_last;

  logic       emit;
  logic       is_last;
  logic [6:0] ch;
  logic       ch_end;

  assign emit = cur_valid && (!out_valid || char_ch.ready);

  // Pick the next character and the job with that character consumed.
  always_comb begin
    cur_next = cur;
    ch_end   = 1'b0;
    if (cur.amp) begin
      ch           = CHAR_AMP;
      cur_next.amp = 1'b0;
    end else if (cur.ndig != 3'd0) begin
      ch            = b64_char(cur.bits[BITS_W-1 -: DIGIT_W]);
      cur_next.ndig = cur.ndig - 3'd1;
      cur_next.bits = {cur.bits[BITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end else if (cur.dash) begin
      ch            = CHAR_DASH;
      cur_next.dash = 1'b0;
    end else if (cur.has_char) begin
      ch                = cur.chr;
      ch_end            = cur.is_end;
      cur_next.has_char = 1'b0;
    end else begin
      ch             = CHAR_DASH;
      cur_next.cdash = 1'b0;
    end
    is_last = !cur_next.amp && (cur_next.ndig == 3'd0) && !cur_next.dash &&
              !cur_next.has_char && !cur_next.cdash;
  end

  assign pop = q_nonempty && (!cur_valid || (emit && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (emit && is_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end else if (emit) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (char_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= ch;
      out_end  <= ch_end;
      out_last <= is_last;
    end
  end

  assign char_ch.valid         = out_valid;
  assign char_ch.out_char      = out_char;
  assign char_ch.end_of_string = out_end;
  assign char_ch.last_of_item  = out_last;

endmodule

// ===== rtl/core/utf8_to_modified_utf7_encoder.sv =====
// Top level of the UTF-8 to IMAP modified UTF-7 encoder.
// Depends on u8m7_pkg, u8m7_ifs, u8m7_front, u8m7_queue and u8m7_back.
// With the back end idle, a request's first character passes the queue, the job register
// and the output register before it is offered.
// Throughput: one character per cycle while the output is not stalled, set by the back end's
// character path; a request makes one to six characters, or none if it only extends a sequence.
// Reset (rst, synchronous, active high) empties queue and output, clears the encoder state
// and turns the space mapping off.
module utf8_to_modified_utf7_encoder import u8m7_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  u8m7_byte_if.sink   byte_ch,
  u8m7_char_if.source char_ch
);

  // The front end accepts one request per cycle while the queue has room. It
  // keeps the whole encoder state (base64 mode, the bits still owed, the
  // UTF-8 sequence being assembled) and turns every byte into a job: the
  // opening '&', up to six base64 digits, the closing '-', a literal
  // character and the '-' that follows a literal '&'. Bytes that only add to
  // an open UTF-8 sequence inside base64 make no job at all.
  logic      push;
  logic      q_full;
  logic      q_nonempty;
  logic      pop;
  u8m7_job_t job;
  u8m7_job_t q_head;

  u8m7_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_ch   (byte_ch),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  // Jobs wait here so that a stalled output does not stop the input at once.
  u8m7_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // The back end walks the job one character at a time. It loads the next
  // job in the same cycle that the last character of the current one goes
  // out, so there is no bubble between requests.
  u8m7_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .char_ch    (char_ch)
  );

endmodule

// ===== rtl/core/u8m7_checker.sv =====
// Port-level checks on the encoder's output channel, and the bind that
// attaches them to utf8_to_modified_utf7_encoder. No package dependencies.
module u8m7_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       end_of_string,
  input logic       last_of_item
);

  // The terminator is always a zero character.
  a_end_is_nul : assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> out_char == 7'h00)
    else $error("terminator with nonzero character");

  // A zero character is only ever the terminator.
  a_nul_is_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 7'h00 |-> end_of_string)
    else $error("zero character without end of string");

  // The terminator closes its request.
  a_end_is_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> last_of_item)
    else $error("terminator not last of request");

  // A stalled character holds.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(end_of_string) && $stable(last_of_item))
    else $error("output changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_idle : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_to_modified_utf7_encoder u8m7_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (char_ch.valid),
  .out_ready     (char_ch.ready),
  .out_char      (char_ch.out_char),
  .end_of_string (char_ch.end_of_string),
  .last_of_item  (char_ch.last_of_item)
);
